FILE: hdl/khta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khta_pkg
// Shared types and constants for the key hit tracker with aging.
// ----------------------------------------------------------------------------
package khta_pkg;

    localparam int HIT_SLOTS_DEF = 8;
    localparam int LED_TOTAL_DEF = 128;

    localparam int OPCODE_W = 2;
    localparam int EDGE_W   = 2;
    localparam int LED_W    = 8;
    localparam int POS_W    = 8;
    localparam int AGE_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_HIT  = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [EDGE_W-1:0] {
        EDGE_BOTH    = 2'd0,
        EDGE_PRESS   = 2'd1,
        EDGE_RELEASE = 2'd2,
        EDGE_ALT     = 2'd3
    } t_edge_sel;

    typedef struct packed {
        logic start;
        logic age_step;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic last_step;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hdl/khta_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khta_ctrl
// Sequencer: accepts one beat, steps the aging pass, holds the result beat.
// ----------------------------------------------------------------------------
module khta_ctrl
    import khta_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_dp_cmd                  o_cmd,
    input  wire t_dp_sts             i_sts
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_AGE  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.start    = 1'b0;
        o_cmd.age_step = 1'b0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_opcode == OP_TICK && !i_sts.cnt_zero) begin
                        n_state = S_AGE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_AGE: begin
                o_cmd.age_step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_age_leads_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AGE && i_sts.last_step) |=> (r_state == S_DONE))
        else $error("aging pass did not finish into result");

    a_tick_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && i_sts.cnt_zero) |=> (r_state == S_DONE))
        else $error("tick on empty list did not complete at once");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !$past(o_cmd.age_step))
        else $error("new beat started during aging pass");

endmodule

`default_nettype wire

FILE: hdl/khta_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khta_datapath
// Entry store as a shift line, hit append, one-entry-per-cycle aging pass
// with compaction by rotation, slot read and result registers.
// ----------------------------------------------------------------------------
module khta_datapath
    import khta_pkg::*;
#(
    parameter int HIT_SLOTS = HIT_SLOTS_DEF,
    parameter int LED_TOTAL = LED_TOTAL_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [EDGE_W-1:0]   i_cfg_edge_select,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic                i_pressed,
    input  wire logic [LED_W-1:0]    i_led_index,
    input  wire logic [POS_W-1:0]    i_led_x,
    input  wire logic [POS_W-1:0]    i_led_y,
    input  wire logic [AGE_W-1:0]    i_delta_ticks,
    input  wire logic [SLOT_W-1:0]   i_read_slot,
    output logic [COUNT_W-1:0]       o_live_count,
    output logic                     o_slot_valid,
    output logic [LED_W-1:0]         o_slot_led,
    output logic [POS_W-1:0]         o_slot_x,
    output logic [POS_W-1:0]         o_slot_y,
    output logic [AGE_W-1:0]         o_slot_age,
    output logic                     o_dropped_oldest,
    output logic [COUNT_W-1:0]       o_expired_count
);

    localparam int CW = $clog2(HIT_SLOTS + 1);
    localparam int IW = (HIT_SLOTS > 1) ? $clog2(HIT_SLOTS) : 1;
    localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

    logic [LED_W-1:0] r_led [HIT_SLOTS];
    logic [POS_W-1:0] r_x   [HIT_SLOTS];
    logic [POS_W-1:0] r_y   [HIT_SLOTS];
    logic [AGE_W-1:0] r_age [HIT_SLOTS];

    logic [EDGE_W-1:0] r_edge_sel;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_left;
    logic [CW-1:0]     r_expired;
    logic [AGE_W-1:0]  r_delta;

    logic              r_valid;
    logic [LED_W-1:0]  r_rd_led;
    logic [POS_W-1:0]  r_rd_x;
    logic [POS_W-1:0]  r_rd_y;
    logic [AGE_W-1:0]  r_rd_age;
    logic              r_dropped;

    logic              take;
    logic              hit_ok;
    logic              full;
    logic [CW-1:0]     cnt_m1;
    logic [AGE_W:0]    age_sum;
    logic              keep;
    logic              shift_en;
    logic              write_en;
    logic [IW-1:0]     wr_idx;
    logic [LED_W-1:0]  wr_led;
    logic [POS_W-1:0]  wr_x;
    logic [POS_W-1:0]  wr_y;
    logic [AGE_W-1:0]  wr_age;
    logic              rd_hit;
    logic [LED_W-1:0]  rd_led;
    logic [POS_W-1:0]  rd_x;
    logic [POS_W-1:0]  rd_y;
    logic [AGE_W-1:0]  rd_age;

    always_comb begin
        case (r_edge_sel)
            EDGE_PRESS:   take = i_pressed;
            EDGE_RELEASE: take = !i_pressed;
            default:      take = 1'b1;
        endcase
    end

    assign hit_ok  = i_cmd.start && (i_opcode == OP_HIT) && take
                     && (i_led_index < LED_W'(LED_TOTAL));
    assign full    = (r_cnt == CW'(HIT_SLOTS));
    assign cnt_m1  = r_cnt - CW'(1);
    assign age_sum = {1'b0, r_age[0]} + {1'b0, r_delta};
    assign keep    = !age_sum[AGE_W];

    assign shift_en = (hit_ok && full) || i_cmd.age_step;
    assign write_en = hit_ok || (i_cmd.age_step && keep);

    always_comb begin
        if (i_cmd.age_step) begin
            wr_idx = cnt_m1[IW-1:0];
            wr_led = r_led[0];
            wr_x   = r_x[0];
            wr_y   = r_y[0];
            wr_age = age_sum[AGE_W-1:0];
        end else begin
            wr_idx = full ? IW'(HIT_SLOTS - 1) : r_cnt[IW-1:0];
            wr_led = i_led_index;
            wr_x   = i_led_x;
            wr_y   = i_led_y;
            wr_age = '0;
        end
    end

    assign rd_hit = (SW'(i_read_slot) < SW'(r_cnt));

    always_comb begin
        rd_led = '0;
        rd_x   = '0;
        rd_y   = '0;
        rd_age = '0;
        for (int k = 0; k < HIT_SLOTS; k++) begin
            if (SW'(k) == SW'(i_read_slot)) begin
                rd_led = r_led[k];
                rd_x   = r_x[k];
                rd_y   = r_y[k];
                rd_age = r_age[k];
            end
        end
    end

    // shift line: advance toward slot 0, then place the new or re-aged entry
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int k = 0; k < HIT_SLOTS - 1; k++) begin
                r_led[k] <= r_led[k+1];
                r_x[k]   <= r_x[k+1];
                r_y[k]   <= r_y[k+1];
                r_age[k] <= r_age[k+1];
            end
        end
        if (write_en) begin
            r_led[wr_idx] <= wr_led;
            r_x[wr_idx]   <= wr_x;
            r_y[wr_idx]   <= wr_y;
            r_age[wr_idx] <= wr_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_delta  <= i_delta_ticks;
            r_rd_led <= (i_opcode == OP_READ && rd_hit) ? rd_led : '0;
            r_rd_x   <= (i_opcode == OP_READ && rd_hit) ? rd_x   : '0;
            r_rd_y   <= (i_opcode == OP_READ && rd_hit) ? rd_y   : '0;
            r_rd_age <= (i_opcode == OP_READ && rd_hit) ? rd_age : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_sel <= EDGE_BOTH;
            r_cnt      <= '0;
            r_left     <= '0;
            r_expired  <= '0;
            r_valid    <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_edge_sel <= i_cfg_edge_select;
            end
            if (i_cmd.start) begin
                r_left    <= r_cnt;
                r_expired <= '0;
                r_valid   <= (i_opcode == OP_READ) && rd_hit;
                r_dropped <= hit_ok && full;
                if (hit_ok && !full) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end else if (i_cmd.age_step) begin
                r_left <= r_left - CW'(1);
                if (!keep) begin
                    r_cnt     <= cnt_m1;
                    r_expired <= r_expired + CW'(1);
                end
            end
        end
    end

    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.last_step = (r_left == CW'(1));

    assign o_live_count     = COUNT_W'(r_cnt);
    assign o_slot_valid     = r_valid;
    assign o_slot_led       = r_rd_led;
    assign o_slot_x         = r_rd_x;
    assign o_slot_y         = r_rd_y;
    assign o_slot_age       = r_rd_age;
    assign o_dropped_oldest = r_dropped;
    assign o_expired_count  = COUNT_W'(r_expired);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(HIT_SLOTS))
        else $error("entry count above slot total");

    a_age_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.age_step |-> (r_left != '0 && r_cnt != '0))
        else $error("aging step with nothing left to visit");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> full)
        else $error("oldest dropped while list not full");

endmodule

`default_nettype wire

FILE: hdl/key_hit_tracker_with_aging_top.sv
`default_nettype none
// Hit and read beats: result beat valid the cycle after the input beat.
// Tick beats: one aging datapath step per live entry, then
//   the result beat; an empty list answers the cycle after the input beat.
// One beat in flight; the next input beat is taken after the result is taken.
// Synchronous active-low reset empties the list and sets edge select to both.
// ----------------------------------------------------------------------------
// key_hit_tracker_with_aging_top
// Bounded ordered list of recent key hits with aging and timed expiry.
// ----------------------------------------------------------------------------
module key_hit_tracker_with_aging_top
    import khta_pkg::*;
#(
    parameter int HIT_SLOTS = HIT_SLOTS_DEF,
    parameter int LED_TOTAL = LED_TOTAL_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [EDGE_W-1:0]   i_cfg_edge_select,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic                i_pressed,
    input  wire logic [LED_W-1:0]    i_led_index,
    input  wire logic [POS_W-1:0]    i_led_x,
    input  wire logic [POS_W-1:0]    i_led_y,
    input  wire logic [AGE_W-1:0]    i_delta_ticks,
    input  wire logic [SLOT_W-1:0]   i_read_slot,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [COUNT_W-1:0]       o_live_count,
    output logic                     o_slot_valid,
    output logic [LED_W-1:0]         o_slot_led,
    output logic [POS_W-1:0]         o_slot_x,
    output logic [POS_W-1:0]         o_slot_y,
    output logic [AGE_W-1:0]         o_slot_age,
    output logic                     o_dropped_oldest,
    output logic [COUNT_W-1:0]       o_expired_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    khta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    khta_datapath #(
        .HIT_SLOTS (HIT_SLOTS),
        .LED_TOTAL (LED_TOTAL)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_edge_select (i_cfg_edge_select),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_opcode),
        .i_pressed         (i_pressed),
        .i_led_index       (i_led_index),
        .i_led_x           (i_led_x),
        .i_led_y           (i_led_y),
        .i_delta_ticks     (i_delta_ticks),
        .i_read_slot       (i_read_slot),
        .o_live_count      (o_live_count),
        .o_slot_valid      (o_slot_valid),
        .o_slot_led        (o_slot_led),
        .o_slot_x          (o_slot_x),
        .o_slot_y          (o_slot_y),
        .o_slot_age        (o_slot_age),
        .o_dropped_oldest  (o_dropped_oldest),
        .o_expired_count   (o_expired_count)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key hit tracker with aging.
// A driver process sends hit, tick, read and no-op beats taken from a queue,
// and a monitor predicts each result from its own copy of the hit list and
// compares every field. Both handshake sides idle at random. The edge-select
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import khta_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 165;

    typedef struct packed {
        t_opcode              op;
        logic                 pressed;
        logic [LED_W-1:0]     led;
        logic [POS_W-1:0]     x;
        logic [POS_W-1:0]     y;
        logic [AGE_W-1:0]     delta;
        logic [SLOT_W-1:0]    slot;
    } t_track_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic                 slot_ok;
        logic [LED_W-1:0]     led;
        logic [POS_W-1:0]     x;
        logic [POS_W-1:0]     y;
        logic [AGE_W-1:0]     age;
        logic                 dropped;
        logic [COUNT_W-1:0]   expired;
    } t_track_rsp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [EDGE_W-1:0]   i_cfg_edge_select = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic                i_pressed = 1'b0;
    logic [LED_W-1:0]    i_led_index = '0;
    logic [POS_W-1:0]    i_led_x = '0;
    logic [POS_W-1:0]    i_led_y = '0;
    logic [AGE_W-1:0]    i_delta_ticks = '0;
    logic [SLOT_W-1:0]   i_read_slot = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [COUNT_W-1:0]  o_live_count;
    logic                o_slot_valid;
    logic [LED_W-1:0]    o_slot_led;
    logic [POS_W-1:0]    o_slot_x;
    logic [POS_W-1:0]    o_slot_y;
    logic [AGE_W-1:0]    o_slot_age;
    logic                o_dropped_oldest;
    logic [COUNT_W-1:0]  o_expired_count;

    key_hit_tracker_with_aging_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_edge_select (i_cfg_edge_select),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_pressed         (i_pressed),
        .i_led_index       (i_led_index),
        .i_led_x           (i_led_x),
        .i_led_y           (i_led_y),
        .i_delta_ticks     (i_delta_ticks),
        .i_read_slot       (i_read_slot),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_live_count      (o_live_count),
        .o_slot_valid      (o_slot_valid),
        .o_slot_led        (o_slot_led),
        .o_slot_x          (o_slot_x),
        .o_slot_y          (o_slot_y),
        .o_slot_age        (o_slot_age),
        .o_dropped_oldest  (o_dropped_oldest),
        .o_expired_count   (o_expired_count)
    );

    t_track_cmd pending_cmds[$];
    t_track_rsp expected_rsps[$];

    t_edge_sel        trk_edge;
    logic [LED_W-1:0] trk_led [HIT_SLOTS_DEF];
    logic [POS_W-1:0] trk_x   [HIT_SLOTS_DEF];
    logic [POS_W-1:0] trk_y   [HIT_SLOTS_DEF];
    logic [AGE_W-1:0] trk_age [HIT_SLOTS_DEF];
    int unsigned      trk_count;

    int   errors = 0;
    int   cycle_cnt = 0;
    logic steady = 1'b0;
    int   hold_ask = 0;
    int   hold_done = 0;
    int   send_gap = 0;
    int   stall_cnt = 0;
    int   hold_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_track_cmd make_cmd(t_opcode op, int pressed, int led, int x, int y,
                                            int delta, int slot);
        t_track_cmd c;
        c.op      = op;
        c.pressed = pressed[0];
        c.led     = LED_W'(led);
        c.x       = POS_W'(x);
        c.y       = POS_W'(y);
        c.delta   = AGE_W'(delta);
        c.slot    = SLOT_W'(slot);
        return c;
    endfunction

    function automatic t_track_cmd random_cmd();
        t_track_cmd  c;
        int unsigned sel;
        c = make_cmd(OP_HIT, $urandom_range(0, 1), $urandom_range(0, LED_TOTAL_DEF - 1),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 65535), $urandom_range(0, 7));
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            if ($urandom_range(0, 9) == 0) c.led = LED_W'($urandom_range(LED_TOTAL_DEF, 255));
        end else if (sel < 65) begin
            c.op = OP_TICK;
            case ($urandom_range(0, 3))
                0: begin
                    c.delta = AGE_W'($urandom_range(0, 15));
                end
                1: begin
                    c.delta = AGE_W'($urandom_range(0, 4095));
                end
                2: begin
                    c.delta = AGE_W'($urandom_range(60000, 65535));
                end
                default: begin
                end
            endcase
        end else if (sel < 95) begin
            c.op = OP_READ;
        end else begin
            c.op = OP_NOP;
        end
        return c;
    endfunction

    // hit list update, one result per beat
    function automatic t_track_rsp advance_tracker(t_track_cmd c);
        t_track_rsp  r;
        logic        take;
        int unsigned i;
        int unsigned k;
        r = '0;
        case (c.op)
            OP_HIT: begin
                if (trk_edge == EDGE_PRESS) take = c.pressed;
                else if (trk_edge == EDGE_RELEASE) take = !c.pressed;
                else take = 1'b1;
                if (take && c.led < LED_TOTAL_DEF) begin
                    if (trk_count >= HIT_SLOTS_DEF) begin
                        for (k = 0; k + 1 < trk_count; k++) begin
                            trk_led[k] = trk_led[k+1];
                            trk_x[k]   = trk_x[k+1];
                            trk_y[k]   = trk_y[k+1];
                            trk_age[k] = trk_age[k+1];
                        end
                        trk_count--;
                        r.dropped = 1'b1;
                    end
                    trk_led[trk_count] = c.led;
                    trk_x[trk_count]   = c.x;
                    trk_y[trk_count]   = c.y;
                    trk_age[trk_count] = '0;
                    trk_count++;
                end
            end
            OP_TICK: begin
                i = 0;
                while (i < trk_count) begin
                    if (17'h0FFFF - c.delta < {1'b0, trk_age[i]}) begin
                        for (k = i; k + 1 < trk_count; k++) begin
                            trk_led[k] = trk_led[k+1];
                            trk_x[k]   = trk_x[k+1];
                            trk_y[k]   = trk_y[k+1];
                            trk_age[k] = trk_age[k+1];
                        end
                        trk_count--;
                        r.expired = r.expired + 1'b1;
                    end else begin
                        trk_age[i] = trk_age[i] + c.delta;
                        i++;
                    end
                end
            end
            OP_READ: begin
                if (c.slot < trk_count) begin
                    r.slot_ok = 1'b1;
                    r.led     = trk_led[c.slot];
                    r.x       = trk_x[c.slot];
                    r.y       = trk_y[c.slot];
                    r.age     = trk_age[c.slot];
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(trk_count);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_track_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                i_opcode      <= c.op;
                i_pressed     <= c.pressed;
                i_led_index   <= c.led;
                i_led_x       <= c.x;
                i_led_y       <= c.y;
                i_delta_ticks <= c.delta;
                i_read_slot   <= c.slot;
                i_in_valid    <= 1'b1;
                send_gap      <= idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result sink with random stalls and a long hold-off on request
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_cnt   <= 0;
            hold_cnt    <= 0;
        end else if (hold_done != hold_ask) begin
            hold_done   <= hold_ask;
            hold_cnt    <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= (hold_cnt == 1);
        end else if (o_out_valid && i_out_ready) begin
            g = idle_len();
            stall_cnt   <= g;
            i_out_ready <= (g == 0);
        end else if (stall_cnt != 0) begin
            stall_cnt   <= stall_cnt - 1;
            i_out_ready <= (stall_cnt == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_track_rsp got;
        t_track_rsp want;
        if (!i_rst_n) begin
            trk_edge  = EDGE_BOTH;
            trk_count = 0;
            for (int n = 0; n < HIT_SLOTS_DEF; n++) begin
                trk_led[n] = '0;
                trk_x[n]   = '0;
                trk_y[n]   = '0;
                trk_age[n] = '1;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) trk_edge = t_edge_sel'(i_cfg_edge_select);
            if (o_out_valid && i_out_ready) begin
                got = {o_live_count, o_slot_valid, o_slot_led, o_slot_x, o_slot_y,
                       o_slot_age, o_dropped_oldest, o_expired_count};
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, live_count %0d",
                             $time, got.count);
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("live_count", want.count, got.count);
                    check_field("slot_valid", want.slot_ok, got.slot_ok);
                    check_field("slot_led", want.led, got.led);
                    check_field("slot_x", want.x, got.x);
                    check_field("slot_y", want.y, got.y);
                    check_field("slot_age", want.age, got.age);
                    check_field("dropped_oldest", want.dropped, got.dropped);
                    check_field("expired_count", want.expired, got.expired);
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_rsps.push_back(advance_tracker(make_cmd(t_opcode'(i_opcode),
                    i_pressed, i_led_index, i_led_x, i_led_y, i_delta_ticks, i_read_slot)));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_rsps.size() != 0);
    endtask

    task automatic write_edge_select(t_edge_sel v);
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_edge_select <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_edge_sel phase_edge [6];
        phase_edge = '{EDGE_PRESS, EDGE_RELEASE, EDGE_ALT, EDGE_BOTH, EDGE_RELEASE, EDGE_PRESS};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_edge_select(EDGE_BOTH);

        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 1, 255, 255, 255, 65535, 7));
        pending_cmds.push_back(make_cmd(OP_HIT, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_HIT, 0, LED_TOTAL_DEF - 1, 255, 255, 65535, 7));
        pending_cmds.push_back(make_cmd(OP_HIT, 1, LED_TOTAL_DEF, 10, 20, 0, 0));
        pending_cmds.push_back(make_cmd(OP_HIT, 0, 255, 30, 40, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 2));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(OP_NOP, 1, 255, 255, 255, 65535, 7));
        for (int n = 0; n < 7; n++) begin
            pending_cmds.push_back(make_cmd(OP_HIT, n & 1, $urandom_range(1, LED_TOTAL_DEF - 2),
                                            $urandom_range(0, 255), $urandom_range(0, 255),
                                            0, 0));
        end
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 7));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 65535, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
        wait_idle();

        foreach (phase_edge[p]) begin
            write_edge_select(phase_edge[p]);
            steady = (p == 1);
            if (p == 2) hold_ask++;
            repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd());
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/khta_pkg.sv
hdl/khta_ctrl.sv
hdl/khta_datapath.sv
hdl/key_hit_tracker_with_aging_top.sv
tb/tb.sv
